// File: design/egsd_pkg.sv
// ----------------------------------------------------------------------------
// egsd_pkg
// Shared types and constants of the edge gap serial deserializer.
// ----------------------------------------------------------------------------
package egsd_pkg;

  localparam int REG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int ZERO_W    = 6;
  localparam int BYTE_W    = 8;
  localparam int POS_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_LEN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd2;

  localparam logic [REG_W-1:0] BIT_LEN_RST      = 24'd20100;
  localparam logic [REG_W-1:0] BLANK_TICKS_RST  = 24'd1000;
  localparam logic [REG_W-1:0] IDLE_TIMEOUT_RST = 24'd800000;

  typedef logic [REG_W-1:0] reg_word_t;

  typedef struct packed {
    logic tick;
    logic clear;
  } tmr_ctl_t;

  typedef struct packed {
    logic              blank_over;
    logic              idle_over;
    logic [ZERO_W-1:0] zeros;
  } tmr_sts_t;

endpackage

// File: design/egsd_timer.sv
// ----------------------------------------------------------------------------
// egsd_timer
// Gap timer: counts ticks since the last edge and whole bit periods in the gap.
// ----------------------------------------------------------------------------
module egsd_timer #(
  parameter int TIMER_WIDTH = 24,
  parameter int MAX_ZEROS   = 63
) (
  input  logic               clk,
  input  logic               rst_n,
  input  egsd_pkg::tmr_ctl_t ctl,
  input  egsd_pkg::reg_word_t bit_len,
  input  egsd_pkg::reg_word_t blank_ticks,
  input  egsd_pkg::reg_word_t idle_timeout,
  output egsd_pkg::tmr_sts_t sts
);
  import egsd_pkg::*;

  localparam int CW = (TIMER_WIDTH > REG_W) ? TIMER_WIDTH : REG_W;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
  localparam logic [ZERO_W-1:0] ZERO_CAP = ZERO_W'((MAX_ZEROS > 63) ? 63 : MAX_ZEROS);

  logic [TIMER_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic [REG_W-1:0]       phase_r, phase_nxt;
  logic [ZERO_W-1:0]      zeros_r, zeros_nxt;
  logic [REG_W:0]         phase_inc;
  logic                   wrap;

  assign phase_inc = {1'b0, phase_r} + {{REG_W{1'b0}}, 1'b1};
  assign wrap      = phase_inc >= {1'b0, bit_len};

  always_comb begin
    elapsed_nxt = elapsed_r;
    phase_nxt   = phase_r;
    zeros_nxt   = zeros_r;
    if (ctl.clear) begin
      elapsed_nxt = '0;
      phase_nxt   = '0;
      zeros_nxt   = '0;
    end else if (ctl.tick) begin
      if (elapsed_r != TIMER_MAX) begin
        elapsed_nxt = elapsed_r + {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
      end
      if (wrap) begin
        phase_nxt = '0;
        if (zeros_r < ZERO_CAP) begin
          zeros_nxt = zeros_r + {{(ZERO_W-1){1'b0}}, 1'b1};
        end
      end else begin
        phase_nxt = phase_inc[REG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      phase_r   <= '0;
      zeros_r   <= '0;
    end else begin
      elapsed_r <= elapsed_nxt;
      phase_r   <= phase_nxt;
      zeros_r   <= zeros_nxt;
    end
  end

  assign sts.blank_over = CW'(elapsed_r) > CW'(blank_ticks);
  assign sts.idle_over  = CW'(elapsed_r) > CW'(idle_timeout);
  assign sts.zeros      = zeros_r;

endmodule

// File: design/edge_gap_serial_deserializer.sv
// ----------------------------------------------------------------------------
// edge_gap_serial_deserializer
// Gap-coded serial receiver that turns edge spacing into bytes, LSB first.
// ----------------------------------------------------------------------------
// An idle sample is handled in ST_READY alone; a sample while receiving passes
// ST_READY, which ticks the gap timer, then ST_EVAL, which classifies it. An
// accepted edge then appends its bits (gap zeros plus the final one) in ST_PUSH,
// and a message end passes ST_FLUSH; both wait while the output is held. A byte
// reaches the output register on the cycle it fills; a held output byte stalls the
// next fill. Synchronous active-low reset restores the register defaults and idles.
module edge_gap_serial_deserializer #(
  parameter int MAX_ZEROS   = 63,
  parameter int TIMER_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_line_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [egsd_pkg::BYTE_W-1:0]       out_data_byte,
  output logic                              out_message_end,
  output logic                              out_run_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [egsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [egsd_pkg::REG_W-1:0]        cfg_data
);
  import egsd_pkg::*;

  localparam logic [1:0] ST_READY = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_PUSH  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  reg_word_t bit_len_r, blank_ticks_r, idle_timeout_r;

  logic [1:0]        state_r, state_nxt;
  logic              receiving_r, receiving_nxt;
  logic              prev_r, prev_nxt;
  logic              lvl_r, lvl_nxt;
  logic [ZERO_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_end_r, out_end_nxt;
  logic              out_last_r, out_last_nxt;

  logic      in_acc, load_ok, push_bit;
  logic [BYTE_W-1:0] filled;
  tmr_ctl_t  tmr_ctl;
  tmr_sts_t  tmr_sts;

  egsd_timer #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .MAX_ZEROS   (MAX_ZEROS)
  ) u_timer (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (tmr_ctl),
    .bit_len      (bit_len_r),
    .blank_ticks  (blank_ticks_r),
    .idle_timeout (idle_timeout_r),
    .sts          (tmr_sts)
  );

  assign in_stall  = (state_r != ST_READY);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign load_ok   = !out_valid_r || !out_stall;
  assign push_bit  = (cnt_r == '0);

  always_comb begin
    filled         = byte_r;
    filled[pos_r]  = push_bit;
  end

  always_comb begin
    state_nxt     = state_r;
    receiving_nxt = receiving_r;
    prev_nxt      = prev_r;
    lvl_nxt       = lvl_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    byte_nxt      = byte_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;
    out_last_nxt  = out_last_r;
    tmr_ctl.tick  = 1'b0;
    tmr_ctl.clear = 1'b0;

    case (state_r)
      ST_READY: begin
        if (in_acc) begin
          if (receiving_r) begin
            tmr_ctl.tick = 1'b1;
            lvl_nxt      = in_line_level;
            state_nxt    = ST_EVAL;
          end else begin
            prev_nxt = in_line_level;
            if (in_line_level) begin
              receiving_nxt = 1'b1;
              tmr_ctl.clear = 1'b1;
              pos_nxt       = '0;
              byte_nxt      = '0;
            end
          end
        end
      end
      ST_EVAL: begin
        prev_nxt  = lvl_r;
        state_nxt = ST_READY;
        if (!prev_r && lvl_r && tmr_sts.blank_over) begin
          cnt_nxt       = tmr_sts.zeros;
          tmr_ctl.clear = 1'b1;
          state_nxt     = ST_PUSH;
        end else if (!prev_r && !lvl_r && tmr_sts.idle_over) begin
          tmr_ctl.clear = 1'b1;
          state_nxt     = ST_FLUSH;
        end
      end
      ST_PUSH: begin
        if (load_ok) begin
          pos_nxt  = pos_r + {{(POS_W-1){1'b0}}, 1'b1};
          byte_nxt = filled;
          if (pos_r == {POS_W{1'b1}}) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = filled;
            out_end_nxt   = 1'b0;
            out_last_nxt  = push_bit || (cnt_r < ZERO_W'(BYTE_W));
            byte_nxt      = '0;
          end
          if (push_bit) begin
            state_nxt = ST_READY;
          end else begin
            cnt_nxt = cnt_r - {{(ZERO_W-1){1'b0}}, 1'b1};
          end
        end
      end
      ST_FLUSH: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = byte_r;
          out_end_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          byte_nxt      = '0;
          pos_nxt       = '0;
          receiving_nxt = 1'b0;
          state_nxt     = ST_READY;
        end
      end
      default: begin
        state_nxt = ST_READY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_len_r      <= BIT_LEN_RST;
      blank_ticks_r  <= BLANK_TICKS_RST;
      idle_timeout_r <= IDLE_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BIT_LEN:      bit_len_r      <= cfg_data;
        REG_BLANK_TICKS:  blank_ticks_r  <= cfg_data;
        REG_IDLE_TIMEOUT: idle_timeout_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_READY;
      receiving_r <= 1'b0;
      prev_r      <= 1'b1;
      lvl_r       <= 1'b0;
      cnt_r       <= '0;
      pos_r       <= '0;
      byte_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      receiving_r <= receiving_nxt;
      prev_r      <= prev_nxt;
      lvl_r       <= lvl_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      byte_r      <= byte_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_data_byte   = out_byte_r;
  assign out_message_end = out_end_r;
  assign out_run_last    = out_last_r;

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_end_r |-> out_last_r)
    else $error("message end byte not marked as last of its sample");

  a_idle_no_zeros: assert property (@(posedge clk) disable iff (!rst_n)
    !receiving_r |-> (tmr_sts.zeros == '0))
    else $error("gap zero count not cleared while idle");

  a_full_byte_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH) && load_ok && (pos_r == {POS_W{1'b1}})
    |=> out_valid_r && !out_end_r)
    else $error("full byte did not reach the output register");

  a_flush_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) && load_ok |=> !receiving_r && (state_r == ST_READY))
    else $error("message end did not return to idle");

endmodule
